// ===== rtl/rnr_pkg.sv =====
// Shared types and constants for the ratio normalize and reduce block.
package rnr_pkg;

  localparam int WORD_W = 32;
  localparam int WIDE_W = 2 * WORD_W;
  localparam int CNT_W  = $clog2(WORD_W);

  typedef struct packed {
    logic [WIDE_W-1:0] numerator_in;
    logic [WIDE_W-1:0] denominator_in;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0] numerator_out;
    logic [WORD_W-1:0] denominator_out;
    logic              zero_denominator;
  } out_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quot;
    logic [WORD_W-1:0] rem;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM,
    ST_CHECK,
    ST_GCD_START,
    ST_GCD_WAIT,
    ST_DIVN_START,
    ST_DIVN_WAIT,
    ST_DIVD_START,
    ST_DIVD_WAIT,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/ratio_normalize_and_reduce.sv =====
// Top level: normalizes a 64-bit ratio to 32 bits and reduces it by Euclid gcd.
// Steps: normalizing right shifts until both values fit in 32 bits, a check, Euclid
// remainder steps until the remainder runs out, the two final divisions
// (one shared 32-step restoring divider), then loading the output; zero cases skip to it.
// A new ratio is taken only in idle, once the last result is in the output register.
// Reset: rst_n is synchronous, active low; clears the sequencer and out_valid.
module ratio_normalize_and_reduce (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rnr_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rnr_pkg::out_t out_data
);

  rnr_pkg::state_t             state_r, state_nxt;
  logic [rnr_pkg::WIDE_W-1:0]  n_r, n_nxt;
  logic [rnr_pkg::WIDE_W-1:0]  d_r, d_nxt;
  logic [rnr_pkg::WORD_W-1:0]  a_r, a_nxt;
  logic [rnr_pkg::WORD_W-1:0]  b_r, b_nxt;
  rnr_pkg::out_t               res_r, res_nxt;
  rnr_pkg::out_t               out_r, out_nxt;
  logic                        out_valid_r, out_valid_nxt;
  rnr_pkg::div_req_t           div_req;
  rnr_pkg::div_rsp_t           div_rsp;
  logic                        in_xfer;
  logic                        out_free;
  logic                        high_set;
  logic [rnr_pkg::WORD_W-1:0]  nn, dd;

  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  // Any bit above the low word means another right shift of both values.
  assign high_set = (n_r[rnr_pkg::WIDE_W-1:rnr_pkg::WORD_W] != '0) ||
                    (d_r[rnr_pkg::WIDE_W-1:rnr_pkg::WORD_W] != '0);
  assign nn = n_r[rnr_pkg::WORD_W-1:0];
  assign dd = d_r[rnr_pkg::WORD_W-1:0];

  rnr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rnr_pkg::ST_IDLE:       if (in_xfer) state_nxt = rnr_pkg::ST_NORM;
      rnr_pkg::ST_NORM:       if (!high_set) state_nxt = rnr_pkg::ST_CHECK;
      rnr_pkg::ST_CHECK: begin
        if (dd == '0 || nn == '0) state_nxt = rnr_pkg::ST_DONE;
        else state_nxt = rnr_pkg::ST_GCD_START;
      end
      rnr_pkg::ST_GCD_START: begin
        // gcd settled once the remainder runs out
        if (b_r == '0) state_nxt = rnr_pkg::ST_DIVN_START;
        else state_nxt = rnr_pkg::ST_GCD_WAIT;
      end
      rnr_pkg::ST_GCD_WAIT:   if (div_rsp.done) state_nxt = rnr_pkg::ST_GCD_START;
      rnr_pkg::ST_DIVN_START: state_nxt = rnr_pkg::ST_DIVN_WAIT;
      rnr_pkg::ST_DIVN_WAIT:  if (div_rsp.done) state_nxt = rnr_pkg::ST_DIVD_START;
      rnr_pkg::ST_DIVD_START: state_nxt = rnr_pkg::ST_DIVD_WAIT;
      rnr_pkg::ST_DIVD_WAIT:  if (div_rsp.done) state_nxt = rnr_pkg::ST_DONE;
      rnr_pkg::ST_DONE:       if (out_free) state_nxt = rnr_pkg::ST_IDLE;
      default:                state_nxt = rnr_pkg::ST_IDLE;
    endcase
  end

  // Datapath updates, divider requests and the output register.
  always_comb begin
    n_nxt            = n_r;
    d_nxt            = d_r;
    a_nxt            = a_r;
    b_nxt            = b_r;
    res_nxt          = res_r;
    out_nxt          = out_r;
    out_valid_nxt    = out_valid_r;
    div_req.start    = 1'b0;
    div_req.dividend = a_r;
    div_req.divisor  = b_r;
    in_ready         = 1'b0;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      rnr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_xfer) begin
          n_nxt = in_data.numerator_in;
          d_nxt = in_data.denominator_in;
        end
      end
      rnr_pkg::ST_NORM: begin
        if (high_set) begin
          n_nxt = n_r >> 1;
          d_nxt = d_r >> 1;
        end
      end
      rnr_pkg::ST_CHECK: begin
        res_nxt.zero_denominator = 1'b0;
        res_nxt.numerator_out    = '0;
        if (dd == '0) begin
          // zero denominator flags an error, numerator dropped
          res_nxt.denominator_out  = '0;
          res_nxt.zero_denominator = 1'b1;
        end else if (nn == '0) begin
          res_nxt.denominator_out = rnr_pkg::WORD_W'(1);
        end
        a_nxt = nn;
        b_nxt = dd;
      end
      rnr_pkg::ST_GCD_START: begin
        div_req.start = (b_r != '0);
      end
      rnr_pkg::ST_GCD_WAIT: begin
        if (div_rsp.done) begin
          a_nxt = b_r;
          b_nxt = div_rsp.rem;
        end
      end
      rnr_pkg::ST_DIVN_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = nn;
        div_req.divisor  = a_r;
      end
      rnr_pkg::ST_DIVN_WAIT: begin
        if (div_rsp.done) res_nxt.numerator_out = div_rsp.quot;
      end
      rnr_pkg::ST_DIVD_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = dd;
        div_req.divisor  = a_r;
      end
      rnr_pkg::ST_DIVD_WAIT: begin
        if (div_rsp.done) res_nxt.denominator_out = div_rsp.quot;
      end
      rnr_pkg::ST_DONE: begin
        // hold the result until the output register frees up
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rnr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/rnr_div.sv =====
// Restoring divider: one quotient bit per cycle, shared by all divisions.
module rnr_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rnr_pkg::div_req_t req,
  output rnr_pkg::div_rsp_t rsp
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [rnr_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [rnr_pkg::WORD_W-1:0]    quo_r, quo_nxt;
  logic [rnr_pkg::WORD_W-1:0]    rem_r, rem_nxt;
  logic [rnr_pkg::WORD_W-1:0]    dsr_r, dsr_nxt;
  logic [rnr_pkg::WORD_W:0]      shifted;
  logic [rnr_pkg::WORD_W:0]      diff;
  logic                          ge;

  assign shifted = {rem_r, quo_r[rnr_pkg::WORD_W-1]};
  assign ge      = shifted >= {1'b0, dsr_r};
  assign diff    = shifted - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      // shift in one dividend bit, subtract when it fits
      quo_nxt = {quo_r[rnr_pkg::WORD_W-2:0], ge};
      rem_nxt = ge ? diff[rnr_pkg::WORD_W-1:0] : shifted[rnr_pkg::WORD_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == rnr_pkg::CNT_W'(rnr_pkg::WORD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== rtl/rnr_checker.sv =====
// Port-level checker for the ratio normalize and reduce block, with its bind.
module rnr_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input rnr_pkg::out_t out_data
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Error results carry zero fields.
  a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_denominator |->
      out_data.numerator_out == '0 && out_data.denominator_out == '0)
    else $error("zero denominator result has nonzero fields");

  // A good result never has a zero denominator.
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.zero_denominator |-> out_data.denominator_out != '0)
    else $error("reduced denominator is zero");

  // The block is busy right after taking an item.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again without working");

endmodule

bind ratio_normalize_and_reduce rnr_checker u_rnr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== dv/testbench.sv =====
// Self-checking testbench for the ratio normalize and reduce block.
`timescale 1ns / 1ps

module testbench;
  import rnr_pkg::*;

  localparam int CLOCK_HALF   = 6;
  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_ITEMS = 800;
  localparam int CALM_ITEMS   = 150;
  localparam int IDLE_PCT     = 14;
  // Drain for longer than the worst item (full normalizing shift, a check, the longest
  // Euclid run, both final divisions) so a stray result still shows up.
  localparam int DRAIN_CYCLES = 2500;
  // Slowest run is about 825 items, each at worst-case length, plus stalls;
  // allow several times that.
  localparam int LIMIT_CYCLES = 5_000_000;

  // Hold the expected reduced ratios in transfer order and check results
  // against them.
  class ratio_board;
    out_t pending[$];
    int   mismatches;

    // Return the leading-one position of a word, or -1 for zero.
    function int top_bit(logic [WORD_W-1:0] w);
      for (int i = WORD_W - 1; i >= 0; i--) begin
        if (w[i]) return i;
      end
      return -1;
    endfunction

    function out_t reduce_ratio(in_t v);
      logic [WIDE_W-1:0] n, d;
      logic [WORD_W-1:0] nn, dd, a, b, r;
      int                pn, pd, sh;
      out_t              res;
      n = v.numerator_in;
      d = v.denominator_in;
      // Shift both down past the highest upper-word leading one.
      if (n[WIDE_W-1:WORD_W] != '0 || d[WIDE_W-1:WORD_W] != '0) begin
        pn = top_bit(n[WIDE_W-1:WORD_W]);
        pd = top_bit(d[WIDE_W-1:WORD_W]);
        sh = ((pn > pd) ? pn : pd) + 1;
        n  = n >> sh;
        d  = d >> sh;
      end
      nn  = n[WORD_W-1:0];
      dd  = d[WORD_W-1:0];
      res = '0;
      if (dd == '0) begin
        res.zero_denominator = 1'b1;
      end else if (nn == '0) begin
        res.denominator_out = 1;
      end else begin
        a = nn;
        b = dd;
        while (b != '0) begin
          r = a % b;
          a = b;
          b = r;
        end
        res.numerator_out   = nn / a;
        res.denominator_out = dd / a;
      end
      return res;
    endfunction

    function void note_ratio_in(in_t v);
      pending.push_back(reduce_ratio(v));
    endfunction

    function void check_ratio_out(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: ratio result with none pending: %h/%h zero=%0b", $realtime,
                   got.numerator_out, got.denominator_out, got.zero_denominator);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (got.numerator_out !== want.numerator_out ||
          got.denominator_out !== want.denominator_out ||
          got.zero_denominator !== want.zero_denominator) begin
        if (mismatches < 10)
          $display("%0t: ratio mismatch: expected %h/%h zero=%0b, got %h/%h zero=%0b",
                   $realtime, want.numerator_out, want.denominator_out,
                   want.zero_denominator, got.numerator_out, got.denominator_out,
                   got.zero_denominator);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_t        in_data;
  logic       out_valid;
  logic       out_ready;
  out_t       out_data;
  int         idle_pct;
  ratio_board board = new();

  ratio_normalize_and_reduce i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #CLOCK_HALF clk = ~clk;

  // Watch both channels at the edge; values read here are the pre-edge ones,
  // so a transfer is seen exactly when the block takes it.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) board.note_ratio_in(in_data);
    if (rst_n && out_valid && out_ready) board.check_ratio_out(out_data);
  end

  // Stall the result side at random; idle_pct drops to zero for the calm stretch.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= idle_pct);
  end

  // Drive one ratio and hold it until the transfer. An optional gap with valid
  // low comes first, so valid is never lowered and raised in the same step.
  task automatic send_ratio(input logic [WIDE_W-1:0] n, input logic [WIDE_W-1:0] d);
    in_t v;
    v.numerator_in   = n;
    v.denominator_in = d;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  // Build an upper word whose leading one sits at position p, random below it.
  function automatic logic [WORD_W-1:0] upper_with_top(int p);
    logic [WORD_W-1:0] low_mask;
    low_mask = (32'd1 << p) - 1;
    return (32'd1 << p) | ($urandom & low_mask);
  endfunction

  task automatic run_directed();
    send_ratio(64'd0, 64'd0);                         // zero over zero
    send_ratio(64'd0, 64'd5);                         // zero numerator
    send_ratio(64'd7, 64'd0);                         // zero denominator
    send_ratio(64'd1, 64'd1);
    send_ratio(64'd12, 64'd18);
    send_ratio(64'd18, 64'd12);                       // numerator above denominator
    send_ratio(64'h0000_0000_FFFF_FFFF, 64'h0000_0000_FFFF_FFFF);
    send_ratio(64'h0000_0000_FFFF_FFFF, 64'd1);
    send_ratio(64'd1, 64'h0000_0000_FFFF_FFFF);
    send_ratio(64'd1836311903, 64'd2971215073);       // consecutive Fibonacci: longest gcd
    send_ratio(64'd4294967291, 64'd4294967279);       // coprime primes
    send_ratio('1, '1);                               // both at the top
    send_ratio('1, 64'd1);                            // denominator shifted to zero
    send_ratio(64'd1, '1);                            // numerator shifted to zero
    send_ratio(64'h0000_0001_0000_0000, 64'h0000_0001_0000_0000); // one-bit shift
    send_ratio(64'h0000_0001_0000_0000, 64'd3);
    send_ratio(64'h0000_0001_0000_0000, 64'd0);
    send_ratio(64'd0, 64'h8000_0000_0000_0000);
    send_ratio(64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000); // full 32-bit shift
    send_ratio(64'h8000_0000_0000_0001, 64'h0000_0000_FFFF_FFFF);
    send_ratio(64'h0000_0003_0000_0006, 64'h0000_0001_0000_0004);
    send_ratio(64'd6, 64'd4);
  endtask

  task automatic run_random();
    logic [WIDE_W-1:0] n, d, t;
    logic [WORD_W-1:0] g;
    int                pick, p;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      // Leave a long stretch with no stalls on either side.
      idle_pct = (k >= RANDOM_ITEMS / 3 && k < RANDOM_ITEMS / 3 + CALM_ITEMS) ? 0 : IDLE_PCT;
      pick     = $urandom_range(99);
      if (pick < 25) begin
        // Both already fit in a word; often small.
        if ($urandom_range(1)) begin
          n = $urandom_range(1000);
          d = $urandom_range(1000);
        end else begin
          n = {32'h0, $urandom};
          d = {32'h0, $urandom};
        end
      end else if (pick < 45) begin
        n = {$urandom, $urandom};
        d = {$urandom, $urandom};
      end else if (pick < 70) begin
        // Shared factor, optionally lifted into the upper words.
        g = $urandom_range(1, 65535);
        n = $urandom_range(65535) * g;
        d = $urandom_range(1, 65535) * g;
        p = $urandom_range(32);
        n = n << p;
        d = d << p;
      end else if (pick < 90) begin
        // Steer the normalizing shift through every leading-one position.
        n = {upper_with_top($urandom_range(31)), $urandom};
        d = {($urandom_range(1) ? upper_with_top($urandom_range(31)) : 32'h0), $urandom};
        if ($urandom_range(1)) begin
          t = n;
          n = d;
          d = t;
        end
      end else begin
        case ($urandom_range(2))
          0: begin
            n = 64'd0;
            d = {$urandom, $urandom};
          end
          1: begin
            n = {$urandom, $urandom};
            d = 64'd0;
          end
          default: begin
            // Denominator small enough to vanish under the shift.
            p = $urandom_range(31);
            n = {upper_with_top(p), $urandom};
            d = {$urandom, $urandom} & ((64'd1 << (p + 1)) - 1);
          end
        endcase
      end
      send_ratio(n, d);
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    idle_pct  = IDLE_PCT;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // End a hung run.
  initial begin
    #(LIMIT_CYCLES * 2 * CLOCK_HALF);
    $display("testbench: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rnr_pkg.sv
rtl/rnr_div.sv
rtl/ratio_normalize_and_reduce.sv
rtl/rnr_checker.sv
dv/testbench.sv
